// ----- sv/scan_ray_segment_intersect_core_assert.svh -----
// Assertion macros for the scan ray crossing core.
`ifndef SCAN_RAY_SEGMENT_INTERSECT_CORE_ASSERT_SVH
`define SCAN_RAY_SEGMENT_INTERSECT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRSI_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRSI_ASSERT_NOW(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define SRSI_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SRSI_ASSERT_NOW(label, clk, rst_n, prop, msg)
`endif
`endif

// ----- sv/srsi_pkg.sv -----
package srsi_pkg;
    localparam int CoordWidth = 32;
    localparam int FracBits   = 16;
    localparam int RotFrac    = 14;
    localparam int WideWidth  = 2 * CoordWidth + 4;
    localparam int QuotBits   = CoordWidth + 2;

    localparam logic [2:0] REG_RAY_START_X = 3'd0;
    localparam logic [2:0] REG_RAY_START_Y = 3'd1;
    localparam logic [2:0] REG_RAY_END_X   = 3'd2;
    localparam logic [2:0] REG_RAY_END_Y   = 3'd3;
    localparam logic [2:0] REG_ROTATION    = 3'd4;
    localparam logic [2:0] REG_OFFSET_X    = 3'd5;
    localparam logic [2:0] REG_OFFSET_Y    = 3'd6;
    localparam logic [2:0] REG_CLOSENESS   = 3'd7;

    localparam logic [63:0] RotReset   = 64'h4000_0000_4000_0000;
    localparam logic [30:0] CloseReset = 31'd9830;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MAP_XX, ST_MAP_XY, ST_MAP_YX, ST_MAP_YY, ST_MAP_SAT,
        ST_CROSS_A, ST_CROSS_B, ST_CLOSE,
        ST_S1A, ST_S1B, ST_S2A, ST_S2B, ST_S3A, ST_S3B, ST_S4A, ST_S4B,
        ST_DECIDE,
        ST_NUM_A, ST_NUM_B, ST_DEN_A, ST_DEN_B,
        ST_DIV_SETUP, ST_DIV_RUN, ST_DIV_DONE,
        ST_OUT
    } state_t;

    // Saturate a wide signed value to a coordinate.
    function automatic logic signed [CoordWidth-1:0] sat_coord(
        input logic signed [WideWidth-1:0] v);
        logic signed [WideWidth-1:0] hi_lim;
        logic signed [WideWidth-1:0] lo_lim;
        begin
            hi_lim = WideWidth'((64'sd1 <<< (CoordWidth - 1)) - 1);
            lo_lim = -WideWidth'(64'sd1 <<< (CoordWidth - 1));
            if (v > hi_lim)
                sat_coord = hi_lim[CoordWidth-1:0];
            else if (v < lo_lim)
                sat_coord = lo_lim[CoordWidth-1:0];
            else
                sat_coord = v[CoordWidth-1:0];
        end
    endfunction
endpackage

// ----- sv/scan_ray_segment_intersect_core.sv -----
// Scan ray crossing core. Each scan point is mapped into the map frame, paired with the
// previous point, and tested against the configured ray segment; the first crossing of a
// scan yields one hit beat. A single 34x34 signed multiplier with a wide accumulator and
// a restoring bit-serial divider do all arithmetic under one sequencer. With no previous
// point or after a hit in the scan, a point is only mapped; a pair that fails the
// closeness test goes straight to the decision, and any other pair runs the four side
// tests first. A crossing adds the general numerator and denominator (general case only),
// one division per coordinate (one for a vertical pair or ray, two otherwise), each of one
// step per multiplier bit plus one for every step that needs a second subtract, plus setup
// and finish, and then the hand-off of the hit. in_ready is low while a point is in work.
// The hit beat waits in an output register while the next point is worked on; a further
// hit holds the sequencer until that beat is delivered.
`include "scan_ray_segment_intersect_core_assert.svh"
module scan_ray_segment_intersect_core
    import srsi_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [63:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [CoordWidth-1:0] point_x,
    input  logic signed [CoordWidth-1:0] point_y,
    input  logic                         scan_start,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [CoordWidth-1:0] hit_x,
    output logic signed [CoordWidth-1:0] hit_y
);
    localparam int MulW = CoordWidth + 2;
    localparam int CntW = $clog2(2 * QuotBits + 1);

    // Configuration registers
    logic signed [CoordWidth-1:0] cx_reg, cy_reg, dx_reg, dy_reg, offx_reg, offy_reg;
    logic [63:0] rot_reg;
    logic [30:0] lim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cx_reg <= '0; cy_reg <= '0; dx_reg <= '0; dy_reg <= '0;
            offx_reg <= '0; offy_reg <= '0;
            rot_reg <= RotReset;
            lim_reg <= CloseReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_RAY_START_X: cx_reg <= cfg_data[CoordWidth-1:0];
                REG_RAY_START_Y: cy_reg <= cfg_data[CoordWidth-1:0];
                REG_RAY_END_X:   dx_reg <= cfg_data[CoordWidth-1:0];
                REG_RAY_END_Y:   dy_reg <= cfg_data[CoordWidth-1:0];
                REG_ROTATION:    rot_reg <= cfg_data;
                REG_OFFSET_X:    offx_reg <= cfg_data[CoordWidth-1:0];
                REG_OFFSET_Y:    offy_reg <= cfg_data[CoordWidth-1:0];
                REG_CLOSENESS:   lim_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Working registers
    state_t state_reg, state_next;
    logic signed [CoordWidth-1:0] px_reg, py_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [CoordWidth-1:0] px_next, py_next, ax_next, ay_next, bx_next, by_next;
    logic prev_valid_reg, prev_valid_next, hit_done_reg, hit_done_next;
    logic signed [WideWidth-1:0] acc_reg, acc_next;
    logic signed [WideWidth-1:0] num_reg, num_next, den_reg, den_next;
    logic [3:0] side_reg, side_next;
    logic pass_x_reg, pass_x_next;   // 1: first division for x, then y
    logic signed [MulW-1:0] m_reg, m_next;
    logic signed [CoordWidth-1:0] base_reg, base_next;
    // Divider: remainder, numerator, divisor magnitudes, quotient, step counter
    logic [WideWidth-1:0] rem_reg, rem_next, nmag_reg, nmag_next, dmag_reg, dmag_next;
    logic [MulW-1:0] mmag_reg, mmag_next;
    logic [QuotBits-1:0] q_reg, q_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic neg_reg, neg_next, sub2_reg, sub2_next;
    logic signed [CoordWidth-1:0] hx_reg, hx_next, hy_reg, hy_next;
    logic signed [CoordWidth-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic out_valid_reg, out_valid_next;

    // Shared multiplier operands
    logic signed [MulW-1:0] mul_a, mul_b;
    logic signed [2*MulW-1:0] mul_p;
    logic signed [WideWidth-1:0] mul_w;
    assign mul_p = mul_a * mul_b;
    assign mul_w = WideWidth'(mul_p);

    function automatic logic signed [MulW-1:0] ext(input logic signed [CoordWidth-1:0] v);
        ext = MulW'(v);
    endfunction

    function automatic logic signed [MulW-1:0] dif(input logic signed [CoordWidth-1:0] a,
                                                   input logic signed [CoordWidth-1:0] b);
        dif = MulW'(a) - MulW'(b);
    endfunction

    // Rotation entries
    logic signed [15:0] r_xx, r_xy, r_yx, r_yy;
    assign r_xx = rot_reg[63:48];
    assign r_xy = rot_reg[47:32];
    assign r_yx = rot_reg[31:16];
    assign r_yy = rot_reg[15:0];

    logic signed [WideWidth-1:0] shifted;
    logic signed [WideWidth-1:0] rem_sh;
    logic [WideWidth-1:0] abs_acc, lim_w;
    logic signed [WideWidth-1:0] qs;
    assign shifted = acc_reg >>> RotFrac;
    assign abs_acc = acc_reg[WideWidth-1] ? WideWidth'(-acc_reg) : WideWidth'(acc_reg);
    assign lim_w = WideWidth'(lim_reg) << FracBits;

    always_comb begin
        state_next = state_reg;
        px_next = px_reg; py_next = py_reg;
        ax_next = ax_reg; ay_next = ay_reg; bx_next = bx_reg; by_next = by_reg;
        prev_valid_next = prev_valid_reg; hit_done_next = hit_done_reg;
        acc_next = acc_reg; num_next = num_reg; den_next = den_reg;
        side_next = side_reg; pass_x_next = pass_x_reg;
        m_next = m_reg; base_next = base_reg;
        rem_next = rem_reg; nmag_next = nmag_reg; dmag_next = dmag_reg;
        mmag_next = mmag_reg; q_next = q_reg; cnt_next = cnt_reg;
        neg_next = neg_reg; sub2_next = sub2_reg;
        hx_next = hx_reg; hy_next = hy_reg;
        out_x_next = out_x_reg; out_y_next = out_y_reg;
        out_valid_next = out_valid_reg;
        mul_a = '0; mul_b = '0;
        rem_sh = '0;
        qs = '0;
        in_ready = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                // Take a point beat
                if (in_valid && in_ready) begin
                    px_next = point_x; py_next = point_y;
                    if (scan_start) begin
                        prev_valid_next = 1'b0;
                        hit_done_next = 1'b0;
                    end
                    acc_next = WideWidth'(offx_reg) <<< RotFrac;
                    state_next = ST_MAP_XX;
                end
            end
            ST_MAP_XX: begin
                mul_a = MulW'(r_xx); mul_b = ext(px_reg);
                acc_next = acc_reg + mul_w;
                state_next = ST_MAP_XY;
            end
            ST_MAP_XY: begin
                mul_a = MulW'(r_xy); mul_b = ext(py_reg);
                acc_next = acc_reg + mul_w;
                state_next = ST_MAP_YX;
            end
            ST_MAP_YX: begin
                bx_next = sat_coord(shifted);
                mul_a = MulW'(r_yx); mul_b = ext(px_reg);
                acc_next = (WideWidth'(offy_reg) <<< RotFrac) + mul_w;
                state_next = ST_MAP_YY;
            end
            ST_MAP_YY: begin
                mul_a = MulW'(r_yy); mul_b = ext(py_reg);
                acc_next = acc_reg + mul_w;
                state_next = ST_MAP_SAT;
            end
            ST_MAP_SAT: begin
                by_next = sat_coord(shifted);
                if (prev_valid_reg && !hit_done_reg) begin
                    state_next = ST_CROSS_A;
                end else begin
                    state_next = ST_IDLE;
                    ax_next = bx_reg; ay_next = sat_coord(shifted);
                    prev_valid_next = 1'b1;
                end
            end
            // |A x B|
            ST_CROSS_A: begin
                mul_a = ext(ax_reg); mul_b = ext(by_reg);
                acc_next = mul_w;
                state_next = ST_CROSS_B;
            end
            ST_CROSS_B: begin
                mul_a = ext(bx_reg); mul_b = ext(ay_reg);
                acc_next = acc_reg - mul_w;
                state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                if (abs_acc < lim_w)
                    state_next = ST_S1A;
                else
                    state_next = ST_DECIDE;
                side_next = '0;
            end
            // Side tests: (B-A)x(C-A), (B-A)x(D-A), (D-C)x(A-C), (D-C)x(B-C)
            ST_S1A: begin
                mul_a = dif(bx_reg, ax_reg); mul_b = dif(cy_reg, ay_reg);
                acc_next = mul_w; state_next = ST_S1B;
            end
            ST_S1B: begin
                mul_a = dif(cx_reg, ax_reg); mul_b = dif(by_reg, ay_reg);
                side_next[0] = (acc_reg - mul_w) <= 0;
                state_next = ST_S2A;
            end
            ST_S2A: begin
                mul_a = dif(bx_reg, ax_reg); mul_b = dif(dy_reg, ay_reg);
                acc_next = mul_w; state_next = ST_S2B;
            end
            ST_S2B: begin
                mul_a = dif(dx_reg, ax_reg); mul_b = dif(by_reg, ay_reg);
                side_next[1] = (acc_reg - mul_w) <= 0;
                state_next = ST_S3A;
            end
            ST_S3A: begin
                mul_a = dif(dx_reg, cx_reg); mul_b = dif(ay_reg, cy_reg);
                acc_next = mul_w; state_next = ST_S3B;
            end
            ST_S3B: begin
                mul_a = dif(ax_reg, cx_reg); mul_b = dif(dy_reg, cy_reg);
                side_next[2] = (acc_reg - mul_w) <= 0;
                state_next = ST_S4A;
            end
            ST_S4A: begin
                mul_a = dif(dx_reg, cx_reg); mul_b = dif(by_reg, cy_reg);
                acc_next = mul_w; state_next = ST_S4B;
            end
            ST_S4B: begin
                mul_a = dif(bx_reg, cx_reg); mul_b = dif(dy_reg, cy_reg);
                side_next[3] = (acc_reg - mul_w) <= 0;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                // Crossing only if both XORs hold and the pair passed closeness
                if (side_reg[0] != side_reg[1] && side_reg[2] != side_reg[3]) begin
                    pass_x_next = 1'b1;
                    if (ax_reg == bx_reg) begin
                        hx_next = ax_reg; pass_x_next = 1'b0;
                        m_next = dif(dy_reg, cy_reg); base_next = cy_reg;
                        num_next = WideWidth'(dif(ax_reg, cx_reg));
                        den_next = WideWidth'(dif(dx_reg, cx_reg));
                        state_next = ST_DIV_SETUP;
                    end else if (cx_reg == dx_reg) begin
                        hx_next = cx_reg; pass_x_next = 1'b0;
                        m_next = dif(by_reg, ay_reg); base_next = ay_reg;
                        num_next = WideWidth'(dif(cx_reg, ax_reg));
                        den_next = WideWidth'(dif(bx_reg, ax_reg));
                        state_next = ST_DIV_SETUP;
                    end else begin
                        state_next = ST_NUM_A;
                    end
                end else begin
                    state_next = ST_IDLE;
                    ax_next = bx_reg; ay_next = by_reg; prev_valid_next = 1'b1;
                end
            end
            // num = (C-A)x(D-C), den = (B-A)x(D-C)
            ST_NUM_A: begin
                mul_a = dif(cx_reg, ax_reg); mul_b = dif(dy_reg, cy_reg);
                acc_next = mul_w; state_next = ST_NUM_B;
            end
            ST_NUM_B: begin
                mul_a = dif(dx_reg, cx_reg); mul_b = dif(cy_reg, ay_reg);
                num_next = acc_reg - mul_w; state_next = ST_DEN_A;
            end
            ST_DEN_A: begin
                mul_a = dif(bx_reg, ax_reg); mul_b = dif(dy_reg, cy_reg);
                acc_next = mul_w; state_next = ST_DEN_B;
            end
            ST_DEN_B: begin
                mul_a = dif(dx_reg, cx_reg); mul_b = dif(by_reg, ay_reg);
                den_next = acc_reg - mul_w;
                m_next = dif(bx_reg, ax_reg); base_next = ax_reg;
                state_next = ST_DIV_SETUP;
            end
            // Prepare m*|num|/|den| with ratio clamped to one
            ST_DIV_SETUP: begin
                neg_next = m_reg[MulW-1] ^ (num_reg[WideWidth-1] ^ den_reg[WideWidth-1]);
                mmag_next = m_reg[MulW-1] ? MulW'(-m_reg) : MulW'(m_reg);
                nmag_next = num_reg[WideWidth-1] ? WideWidth'(-num_reg) : WideWidth'(num_reg);
                dmag_next = den_reg[WideWidth-1] ? WideWidth'(-den_reg) : WideWidth'(den_reg);
                rem_next = '0; q_next = '0;
                cnt_next = CntW'(MulW);
                sub2_next = 1'b0;
                state_next = ST_DIV_RUN;
                if (nmag_next > dmag_next) nmag_next = dmag_next;
            end
            // One multiplier bit per step: shift, add, then up to two subtracts
            ST_DIV_RUN: begin
                if (dmag_reg == '0) begin
                    state_next = ST_DIV_DONE;
                end else if (!sub2_reg) begin
                    rem_sh = (rem_reg << 1) + (mmag_reg[MulW-1] ? nmag_reg : '0);
                    mmag_next = mmag_reg << 1;
                    q_next = q_reg << 1;
                    if (rem_sh >= dmag_reg) begin
                        rem_next = rem_sh - dmag_reg;
                        q_next = (q_reg << 1) + 1'b1;
                        sub2_next = 1'b1;
                    end else begin
                        rem_next = rem_sh;
                    end
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CntW'(1) && !(rem_sh >= dmag_reg))
                        state_next = ST_DIV_DONE;
                end else begin
                    if (rem_reg >= dmag_reg) begin
                        rem_next = rem_reg - dmag_reg;
                        q_next = q_reg + 1'b1;
                    end
                    sub2_next = 1'b0;
                    if (cnt_reg == '0)
                        state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE: begin
                if (dmag_reg == '0)
                    qs = neg_reg ? -(WideWidth'(64'sd1) <<< CoordWidth)
                                 : (WideWidth'(64'sd1) <<< CoordWidth);
                else
                    qs = neg_reg ? -WideWidth'(q_reg) : WideWidth'(q_reg);
                if (pass_x_reg) begin
                    hx_next = sat_coord(WideWidth'(base_reg) + qs);
                    m_next = dif(by_reg, ay_reg); base_next = ay_reg;
                    pass_x_next = 1'b0;
                    state_next = ST_DIV_SETUP;
                end else begin
                    hy_next = sat_coord(WideWidth'(base_reg) + qs);
                    state_next = ST_OUT;
                end
            end
            // Hold until the output register is free, then hand off the hit beat
            ST_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_x_next = hx_reg;
                    out_y_next = hy_reg;
                    hit_done_next = 1'b1;
                    ax_next = bx_reg; ay_next = by_reg; prev_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            prev_valid_reg <= 1'b0;
            hit_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ax_reg <= '0;
            ay_reg <= '0;
        end else begin
            state_reg <= state_next;
            prev_valid_reg <= prev_valid_next;
            hit_done_reg <= hit_done_next;
            out_valid_reg <= out_valid_next;
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk) begin
        px_reg <= px_next; py_reg <= py_next;
        bx_reg <= bx_next; by_reg <= by_next;
        acc_reg <= acc_next; num_reg <= num_next; den_reg <= den_next;
        side_reg <= side_next; pass_x_reg <= pass_x_next;
        m_reg <= m_next; base_reg <= base_next;
        rem_reg <= rem_next; nmag_reg <= nmag_next; dmag_reg <= dmag_next;
        mmag_reg <= mmag_next; q_reg <= q_next; cnt_reg <= cnt_next;
        neg_reg <= neg_next; sub2_reg <= sub2_next;
        hx_reg <= hx_next; hy_reg <= hy_next;
        out_x_reg <= out_x_next; out_y_reg <= out_y_next;
    end

    assign out_valid = out_valid_reg;
    assign hit_x = out_x_reg;
    assign hit_y = out_y_reg;

    `SRSI_ASSERT_IMPL(a_no_take_busy, clk, rst_n,
        (state_reg != ST_IDLE) |-> !in_ready, "point taken while busy")
    `SRSI_ASSERT_IMPL(a_hit_sets_done, clk, rst_n,
        (state_reg == ST_OUT && (!out_valid_reg || out_ready)) |=>
        (hit_done_reg && out_valid_reg), "hit not recorded")
    `SRSI_ASSERT_NOW(a_out_hold, clk, rst_n,
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_x_reg)),
        "hit beat dropped")
endmodule

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import srsi_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               first;
    } scan_point_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } hit_point_t;

    localparam int ONE        = 65536;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 200;
    localparam int WATCHDOG   = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic scan_start = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;

    // Shadow registers and state of the crossing predictor
    logic signed [31:0] ray_cx, ray_cy, ray_dx, ray_dy, shift_x, shift_y;
    logic [63:0] rot_terms;
    logic [30:0] close_lim;
    logic signed [31:0] last_x, last_y;
    bit last_ok, scan_hit;

    scan_point_t point_fifo[$];
    hit_point_t  pending_hits[$];
    int src_idle = 0;
    int snk_idle = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_cnt = 0;
    int idle_cycles = 0;
    int errors = 0;
    int n_points = 0;
    int n_hits = 0;

    scan_ray_segment_intersect_core i_dut (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic wide_t wx(input logic signed [63:0] v);
        wx = v;
    endfunction

    function automatic wide_t sat32(input wide_t v);
        wide_t hi_lim, lo_lim;
        hi_lim = wx(64'sd2147483647);
        lo_lim = wx(-64'sd2147483648);
        if (v > hi_lim)
            sat32 = hi_lim;
        else if (v < lo_lim)
            sat32 = lo_lim;
        else
            sat32 = v;
    endfunction

    function automatic wide_t map_axis(input wide_t r0, r1, off, px, py);
        wide_t s;
        s = r0 * px + r1 * py + (off <<< RotFrac);
        map_axis = sat32(s >>> RotFrac);
    endfunction

    function automatic wide_t wabs(input wide_t v);
        wabs = (v < 0) ? -v : v;
    endfunction

    // m * num / den truncated toward zero, ratio clamped to one
    function automatic wide_t scale(input wide_t m, num, den);
        bit neg;
        wide_t n, d, q;
        neg = (m < 0) ^ ((num < 0) ^ (den < 0));
        n = wabs(num);
        d = wabs(den);
        if (d == 0) begin
            q = wx(64'sd1) <<< 32;
        end
        else begin
            if (n > d)
                n = d;
            q = (wabs(m) * n) / d;
        end
        scale = neg ? -q : q;
    endfunction

    function automatic bit on_right(input wide_t px, py, qx, qy, rx, ry);
        wide_t k;
        k = (qx - px) * (ry - py) - (rx - px) * (qy - py);
        on_right = (k <= 0);
    endfunction

    task automatic apply_reg(input logic [2:0] idx, input logic [63:0] data);
        case (idx)
            REG_RAY_START_X: ray_cx = data[31:0];
            REG_RAY_START_Y: ray_cy = data[31:0];
            REG_RAY_END_X:   ray_dx = data[31:0];
            REG_RAY_END_Y:   ray_dy = data[31:0];
            REG_ROTATION:    rot_terms = data;
            REG_OFFSET_X:    shift_x = data[31:0];
            REG_OFFSET_Y:    shift_y = data[31:0];
            REG_CLOSENESS:   close_lim = data[30:0];
            default: ;
        endcase
    endtask

    // Map one point, test the pair against the ray and queue any crossing
    task automatic predict_crossing(input logic signed [31:0] px, py, input logic first);
        wide_t bx, by, ax, ay, cx, cy, dx, dy, c, lim, num, den, hx, hy;
        hit_point_t h;
        if (first) begin
            last_ok = 0;
            scan_hit = 0;
        end
        bx = map_axis(wx($signed(rot_terms[63:48])), wx($signed(rot_terms[47:32])),
                      wx(shift_x), wx(px), wx(py));
        by = map_axis(wx($signed(rot_terms[31:16])), wx($signed(rot_terms[15:0])),
                      wx(shift_y), wx(px), wx(py));
        ax = wx(last_x);
        ay = wx(last_y);
        cx = wx(ray_cx);
        cy = wx(ray_cy);
        dx = wx(ray_dx);
        dy = wx(ray_dy);
        if (last_ok && !scan_hit) begin
            c = wabs(ax * by - bx * ay);
            lim = wx($signed({33'b0, close_lim})) <<< FracBits;
            if (c < lim &&
                (on_right(ax, ay, bx, by, cx, cy) != on_right(ax, ay, bx, by, dx, dy)) &&
                (on_right(cx, cy, dx, dy, ax, ay) != on_right(cx, cy, dx, dy, bx, by))) begin
                if (ax == bx) begin
                    hx = ax;
                    hy = sat32(cy + scale(dy - cy, ax - cx, dx - cx));
                end
                else if (cx == dx) begin
                    hx = cx;
                    hy = sat32(ay + scale(by - ay, cx - ax, bx - ax));
                end
                else begin
                    num = (cx - ax) * (dy - cy) - (dx - cx) * (cy - ay);
                    den = (bx - ax) * (dy - cy) - (dx - cx) * (by - ay);
                    hx = sat32(ax + scale(bx - ax, num, den));
                    hy = sat32(ay + scale(by - ay, num, den));
                end
                h.x = hx[31:0];
                h.y = hy[31:0];
                pending_hits.push_back(h);
                scan_hit = 1;
            end
        end
        last_x = bx[31:0];
        last_y = by[31:0];
        last_ok = 1;
    endtask

    // Point driver: offer the next queued point, idle at random
    always @(posedge clk or negedge rst_n) begin
        scan_point_t p;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                predict_crossing(point_x, point_y, scan_start);
                n_points++;
            end
            if (!in_valid || in_ready) begin
                if (point_fifo.size() > 0 && $urandom_range(99) >= src_idle) begin
                    p = point_fifo.pop_front();
                    point_x <= p.x;
                    point_y <= p.y;
                    scan_start <= p.first;
                    in_valid <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Hit monitor: compare each beat with the oldest predicted crossing
    always @(posedge clk or negedge rst_n) begin
        hit_point_t e;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                n_hits++;
                if (pending_hits.size() == 0) begin
                    $error("unexpected hit beat x=%0d y=%0d", hit_x, hit_y);
                    errors++;
                end
                else begin
                    e = pending_hits.pop_front();
                    if (hit_x !== e.x) begin
                        $error("hit_x mismatch: expected %0d, actual %0d", e.x, hit_x);
                        errors++;
                    end
                    if (hit_y !== e.y) begin
                        $error("hit_y mismatch: expected %0d, actual %0d", e.y, hit_y);
                        errors++;
                    end
                end
            end
            out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= snk_idle);
        end
    end

    // Long receiver hold-off on request
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_cnt <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_LEN;
        end
        else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG);
            $display("status: fail");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] with_noise(input logic signed [31:0] v);
        with_noise = {$urandom(), v};
    endfunction

    function automatic logic signed [31:0] rnd_span(input int span);
        rnd_span = int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic set_ray(input int cx, cy, dx, dy);
        cfg_write(REG_RAY_START_X, with_noise(cx));
        cfg_write(REG_RAY_START_Y, with_noise(cy));
        cfg_write(REG_RAY_END_X, with_noise(dx));
        cfg_write(REG_RAY_END_Y, with_noise(dy));
    endtask

    task automatic set_frame(input logic [63:0] rot, input int ox, oy, input logic [30:0] lim);
        cfg_write(REG_ROTATION, rot);
        cfg_write(REG_OFFSET_X, with_noise(ox));
        cfg_write(REG_OFFSET_Y, with_noise(oy));
        cfg_write(REG_CLOSENESS, {$urandom(), 1'b0, lim} ^ {33'h0, 31'h0});
    endtask

    // Random ray and frame; rotation entries within plus or minus one
    task automatic random_setting(input int span);
        logic [15:0] r[4];
        int cx;
        cx = rnd_span(span);
        if ($urandom_range(3) == 0)
            set_ray(cx, rnd_span(span), cx, rnd_span(span));
        else
            set_ray(cx, rnd_span(span), rnd_span(span), rnd_span(span));
        if ($urandom_range(2) == 0) begin
            set_frame(64'h4000_0000_0000_4000, 0, 0, 31'h7FFF_FFFF);
        end
        else begin
            foreach (r[i])
                r[i] = 16'(rnd_span(16'h4000));
            set_frame({r[0], r[1], r[2], r[3]}, rnd_span(span / 2), rnd_span(span / 2),
                      31'h7FFF_FFFF);
        end
    endtask

    task automatic push_point(input logic signed [31:0] x, y, input logic first);
        scan_point_t p;
        p.x = x;
        p.y = y;
        p.first = first;
        point_fifo.push_back(p);
    endtask

    // One scan: a random walk, with repeated x now and then
    task automatic gen_scan(input int len, input int span);
        logic signed [31:0] x, y;
        x = rnd_span(span);
        y = rnd_span(span);
        push_point(x, y, 1'b1);
        for (int i = 1; i < len; i++) begin
            if ($urandom_range(6) != 0)
                x = x + rnd_span(span / 2);
            y = y + rnd_span(span / 2);
            push_point(x, y, 1'b0);
        end
    endtask

    task automatic run_random(input int n_items, input int span);
        int count;
        int len;
        count = 0;
        while (count < n_items) begin
            if ($urandom_range(4) == 0) begin
                push_point($urandom(), $urandom(), 1'($urandom_range(1)));
                count++;
            end
            else begin
                len = $urandom_range(2, 10);
                gen_scan(len, span);
                count += len;
            end
        end
    endtask

    // Drop back to idle: all points taken, all hits seen, block settled
    task automatic drain;
        while (point_fifo.size() != 0 || in_valid || pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: horizontal ray from -4 to 4 on y = 0, identity frame
        set_ray(-4 * ONE, 0, 4 * ONE, 0);
        set_frame(64'h4000_0000_0000_4000, 0, 0, 31'h7FFF_FFFF);
        push_point(ONE, ONE, 1'b1);
        push_point(ONE, -ONE, 1'b0);
        push_point(2 * ONE, ONE, 1'b0);
        push_point(ONE / 2, -ONE, 1'b1);
        push_point(ONE + 123, ONE, 1'b0);
        push_point(-3 * ONE, -ONE, 1'b0);
        push_point(5 * ONE, ONE, 1'b1);
        push_point(5 * ONE, -ONE, 1'b0);
        push_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        push_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        push_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        push_point(0, 0, 1'b0);
        drain();
        // Directed: vertical ray at x = 1, rotated frame with offset
        set_ray(ONE, -4 * ONE, ONE, 4 * ONE);
        set_frame(64'h0000_4000_C000_0000, ONE / 4, -ONE / 8, 31'h7FFF_FFFF);
        push_point(ONE, 0, 1'b1);
        push_point(-ONE, 2 * ONE, 1'b0);
        push_point(ONE, 3 * ONE, 1'b0);
        push_point(-ONE, -3 * ONE, 1'b0);
        drain();
        // Directed: extreme frame and zero limit, no pair can pass
        set_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        set_frame(64'h7FFF_8000_7FFF_8000, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'd0);
        push_point(ONE, ONE, 1'b1);
        push_point(-ONE, ONE, 1'b0);
        push_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        drain();

        // Random: sender idles lightly, receiver heavily
        src_idle <= 10;
        snk_idle <= 63;
        for (int k = 0; k < 4; k++) begin
            random_setting(1 << 20);
            run_random(95, 1 << 20);
            drain();
        end
        // Random: roles swapped, with a long receiver hold-off at the start
        src_idle <= 63;
        snk_idle <= 10;
        random_setting(1 << 20);
        hold_req <= hold_req + 1;
        run_random(95, 1 << 20);
        drain();
        for (int k = 0; k < 3; k++) begin
            random_setting(1 << 18);
            run_random(95, 1 << 18);
            drain();
        end
        // Random: no idling; first full-range frame and default-like limit
        src_idle <= 0;
        snk_idle <= 0;
        set_ray($urandom(), $urandom(), $urandom(), $urandom());
        set_frame({$urandom(), $urandom()}, $urandom(), $urandom(), 31'd9830);
        run_random(100, 1 << 30);
        drain();
        for (int k = 0; k < 3; k++) begin
            random_setting(1 << 20);
            hold_req <= hold_req + 1;
            run_random(95, 1 << 20);
            drain();
        end

        $display("covered %0d scan points and %0d hit beats over 15 register settings",
                 n_points, n_hits);
        $display("three idle profiles, receiver hold-offs, vertical and general crossings");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/srsi_pkg.sv
sv/scan_ray_segment_intersect_core.sv
test/tb.sv
